FILE: hdl/msrp_pkg.sv
// ----------------------------------------------------------------------------
// msrp_pkg
// shared types and constants of the min speed ratio path unit
// ----------------------------------------------------------------------------
`default_nettype none
package msrp_pkg;
   localparam int unsigned VtxWidth = 10;
   localparam int unsigned SpdWidth = 16;

   typedef enum logic [1:0] {
      CSR_VERTEX_COUNT  = 2'd0,
      CSR_SOURCE_VERTEX = 2'd1,
      CSR_TARGET_VERTEX = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [VtxWidth-1:0] end_a;
      logic [VtxWidth-1:0] end_b;
      logic [SpdWidth-1:0] speed;
      logic                last_edge;
   } req_payload_type;

   typedef struct packed {
      logic                impossible;
      logic [SpdWidth-1:0] ratio_num;
      logic [SpdWidth-1:0] ratio_den;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_CHECK,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_START,
      ST_CLEAR,
      ST_EDGE_RD,
      ST_EDGE_GET,
      ST_FIND_A,
      ST_FIND_B,
      ST_LINK,
      ST_FIND_S,
      ST_FIND_T,
      ST_NEXT,
      ST_GCD,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: hdl/msrp_edge_mem.sv
// ----------------------------------------------------------------------------
// msrp_edge_mem
// edge store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module msrp_edge_mem #(
   parameter int unsigned DEPTH = 8192,
   parameter int unsigned WIDTH = 34,
   parameter int unsigned AW    = 13
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/msrp_divider.sv
// ----------------------------------------------------------------------------
// msrp_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module msrp_divider #(
   parameter int unsigned W = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);
   localparam int unsigned CW = $clog2(W + 1);
   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

FILE: hdl/min_speed_ratio_path_unit.sv
// ----------------------------------------------------------------------------
// min_speed_ratio_path_unit
// smallest max/min speed ratio on a route, by sorted edges and union-find
// ----------------------------------------------------------------------------
//   channel | direction | handshake       | payload
//   req_    | in        | valid / stall   | req_payload_type
//   rsp_    | out       | valid / stall   | rsp_payload_type
//   csr_    | in        | valid / ready   | index, data
// edges load one per cycle into the edge store memory while req_stall is low
// after the last edge: insertion sort in memory, then per distinct start speed
// a forest clear of every vertex in use and a join of edges in sorted order
// with path-halving finds, then a gcd by the shared divider
// reset is synchronous; the memories need no clearing pass
// a result waiting on rsp_stall holds back only the next result
`default_nettype none
module min_speed_ratio_path_unit #(
   parameter int unsigned MAX_VERTICES = 512,
   parameter int unsigned MAX_EDGES    = 8192,
   parameter int unsigned SPEED_BITS   = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire msrp_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output msrp_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [9:0]                csr_data
);
   import msrp_pkg::*;

   localparam int unsigned VW   = $clog2(MAX_VERTICES);
   localparam int unsigned VCAP = (MAX_VERTICES > 1023) ? 1023 : MAX_VERTICES;
   localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
   localparam int unsigned SW   = (SPEED_BITS < SpdWidth) ? SPEED_BITS : SpdWidth;
   localparam int unsigned EW   = 2 * VtxWidth + SW;

   // configuration
   logic [VtxWidth-1:0] vcnt_ff, src_ff, tgt_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff <= VtxWidth'(2);
         src_ff  <= VtxWidth'(1);
         tgt_ff  <= VtxWidth'(2);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vcnt_ff <= csr_data;
            CSR_SOURCE_VERTEX: src_ff  <= csr_data;
            CSR_TARGET_VERTEX: tgt_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [VtxWidth:0] nv;
   assign nv = ({1'b0, vcnt_ff} > (VtxWidth+1)'(VCAP)) ?
               (VtxWidth+1)'(VCAP) : {1'b0, vcnt_ff};

   function automatic logic in_rng(input logic [VtxWidth-1:0] v,
                                   input logic [VtxWidth:0] n);
      in_rng = (v != '0) && ({1'b0, v} <= n);
   endfunction

   // edge memory
   logic           em_we;
   logic [EAW-1:0] em_wa, em_ra;
   logic [EW-1:0]  em_wd, em_rd;
   msrp_edge_mem #(.DEPTH(MAX_EDGES), .WIDTH(EW), .AW(EAW)) u_edges (
      .clock(clock), .wr_en(em_we), .wr_addr(em_wa), .wr_data(em_wd),
      .rd_addr(em_ra), .rd_data(em_rd)
   );

   // forest memory
   logic          pm_we;
   logic [VW-1:0] pm_wa, pm_ra, pm_wd, pm_rd;
   logic [VW-1:0] pmem [MAX_VERTICES];
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[pm_wa] <= pm_wd;
      end
      pm_rd <= pmem[pm_ra];
   end

   // divider
   logic          dv_start, dv_busy;
   logic [SW-1:0] dv_a, dv_b, dv_q, dv_r;
   msrp_divider #(.W(SW)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_a),
      .divisor(dv_b), .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
   );

   state_type state_ff, state_in;
   logic [ECW-1:0] cnt_ff, cnt_in;       // edge count
   logic [ECW-1:0] i_ff, i_in;           // sort index / start edge
   logic [ECW-1:0] k_ff, k_in;           // sort position / join edge
   logic [EW-1:0]  key_ff, key_in;       // edge being inserted
   logic [SW-1:0]  hi_ff, hi_in, prev_ff, prev_in;
   logic           havep_ff, havep_in;
   logic [VW-1:0]  x_ff, x_in, ra_ff, ra_in, rs_ff, rs_in;
   logic [VtxWidth-1:0] eb_ff, eb_in;
   logic [SW-1:0]  lo_ff, lo_in;
   logic           cur_ff, cur_in;       // join edge read, not start edge; after find T: source and target joined
   logic [VW-1:0]  pp_ff, pp_in;         // parent of x
   logic           ph_ff, ph_in;         // 0: read parent of x, 1: parent of parent
   logic [SW-1:0]  bmax_ff, bmax_in, bmin_ff, bmin_in;
   logic           bfound_ff, bfound_in;
   logic [SW-1:0]  ga_ff, ga_in, gb_ff, gb_in;
   logic [1:0]     dph_ff, dph_in;
   logic           rv_ff, rv_in;
   rsp_payload_type rp_ff, rp_in;
   rsp_payload_type rr_ff, rr_in;        // finished result before output
   logic [2*SW-1:0] lhs, rhs;

   logic [SW-1:0] in_spd;
   assign in_spd = req_payload.speed[SW-1:0];

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rv_ff;
   assign rsp_payload = rp_ff;

   logic [VtxWidth-1:0] e_a, e_b;
   logic [SW-1:0]       e_s;
   assign e_a = em_rd[EW-1 -: VtxWidth];
   assign e_b = em_rd[SW +: VtxWidth];
   assign e_s = em_rd[SW-1:0];

   assign lhs = bmax_ff * lo_ff;
   assign rhs = hi_ff * bmin_ff;

   // next state, with the datapath updates
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      key_in    = key_ff;
      hi_in     = hi_ff;
      prev_in   = prev_ff;
      havep_in  = havep_ff;
      x_in      = x_ff;
      ra_in     = ra_ff;
      rs_in     = rs_ff;
      eb_in     = eb_ff;
      lo_in     = lo_ff;
      cur_in    = cur_ff;
      pp_in     = pp_ff;
      ph_in     = ph_ff;
      bmax_in   = bmax_ff;
      bmin_in   = bmin_ff;
      bfound_in = bfound_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      dph_in    = dph_ff;
      rv_in     = rv_ff && rsp_stall;
      rp_in     = rp_ff;
      rr_in     = rr_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && !req_stall) begin
               if (in_spd != '0 && cnt_ff < ECW'(MAX_EDGES)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_payload.last_edge) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            bfound_in = 1'b0;
            bmax_in   = '0;
            bmin_in   = '0;
            havep_in  = 1'b0;
            if (!(in_rng(src_ff, nv) && in_rng(tgt_ff, nv))) begin
               state_in = ST_GCD;
            end else begin
               i_in     = ECW'(1);
               state_in = (cnt_ff > ECW'(1)) ? ST_SORT_RD : ST_START;
               if (cnt_ff <= ECW'(1)) begin
                  i_in = '0;
               end
            end
         end
         // insertion: read key at i, then walk k down, shifting smaller entries
         ST_SORT_RD: begin
            k_in     = i_ff;
            ph_in    = 1'b0;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (!ph_ff) begin
               key_in = em_rd;
               ph_in  = 1'b1;
            end else if (k_ff != '0 && e_s < key_ff[SW-1:0]) begin
               k_in = k_ff - 1'b1;
            end else begin
               i_in  = i_ff + 1'b1;
               ph_in = 1'b0;
               if (i_ff + 1'b1 == cnt_ff) begin
                  i_in     = '0;
                  state_in = ST_START;
               end else begin
                  k_in = i_ff + 1'b1;
               end
            end
         end
         ST_START: begin
            if (i_ff == cnt_ff) begin
               state_in = ST_GCD;
            end else begin
               ph_in    = 1'b0;
               state_in = ST_EDGE_RD;
               x_in     = '0;
               k_in     = i_ff;
               cur_in   = 1'b1;
            end
         end
         ST_EDGE_RD: begin
            state_in = ST_EDGE_GET;
         end
         ST_EDGE_GET: begin
            if (!cur_ff) begin
               // first read of a start edge decides whether it is skipped
               if (havep_ff && e_s == prev_ff) begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_START;
               end else begin
                  hi_in    = e_s;
                  prev_in  = e_s;
                  havep_in = 1'b1;
                  x_in     = '0;
                  state_in = ST_CLEAR;
               end
            end else begin
               lo_in = e_s;
               eb_in = e_b;
               if (in_rng(e_a, nv) && in_rng(e_b, nv)) begin
                  x_in     = VW'(e_a - 1'b1);
                  ph_in    = 1'b0;
                  state_in = ST_FIND_A;
               end else begin
                  x_in     = VW'(src_ff - 1'b1);
                  ph_in    = 1'b0;
                  state_in = ST_FIND_S;
               end
            end
         end
         ST_CLEAR: begin
            x_in = x_ff + 1'b1;
            if ({1'b0, x_ff} + 1'b1 == (VW+1)'(nv)) begin
               cur_in   = 1'b1;
               state_in = ST_EDGE_RD;
            end
         end
         // find with path halving: read parent, then grandparent, write back
         ST_FIND_A, ST_FIND_B, ST_FIND_S, ST_FIND_T: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
               pp_in = x_ff;
            end else if (pm_rd == x_ff && pp_ff == x_ff) begin
               ph_in = 1'b0;
               unique case (state_ff)
                  ST_FIND_A: begin
                     ra_in = x_ff;
                     x_in  = VW'(eb_ff - 1'b1);
                     state_in = ST_FIND_B;
                  end
                  ST_FIND_B: begin
                     state_in = ST_LINK;
                  end
                  ST_FIND_S: begin
                     rs_in = x_ff;
                     x_in  = VW'(tgt_ff - 1'b1);
                     state_in = ST_FIND_T;
                  end
                  default: begin
                     state_in = ST_NEXT;
                     cur_in   = (rs_ff == x_ff);
                  end
               endcase
            end else if (pp_ff == x_ff) begin
               pp_in = pm_rd;
            end else begin
               x_in  = pm_rd;
               ph_in = 1'b0;
            end
         end
         ST_LINK: begin
            x_in     = VW'(src_ff - 1'b1);
            ph_in    = 1'b0;
            state_in = ST_FIND_S;
         end
         ST_NEXT: begin
            if (cur_ff) begin
               if (!bfound_ff || lhs > rhs) begin
                  bmax_in   = hi_ff;
                  bmin_in   = lo_ff;
                  bfound_in = 1'b1;
               end
               i_in     = i_ff + 1'b1;
               state_in = ST_START;
            end else if (k_ff + 1'b1 == cnt_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_START;
            end else begin
               k_in     = k_ff + 1'b1;
               cur_in   = 1'b1;
               state_in = ST_EDGE_RD;
            end
         end
         ST_GCD: begin
            if (!bfound_ff) begin
               rr_in    = '{impossible: 1'b1, ratio_num: '0, ratio_den: '0};
               state_in = ST_OUT;
            end else if (dph_ff == 2'd0) begin
               ga_in  = bmax_ff;
               gb_in  = bmin_ff;
               dph_in = 2'd1;
            end else if (!dv_busy) begin
               if (dph_ff == 2'd2) begin
                  ga_in = gb_ff;
                  gb_in = dv_r;
               end
               dph_in = 2'd2;
               if (dph_ff == 2'd2 && dv_r == '0) begin
                  dph_in   = 2'd0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!dv_busy) begin
               if (dph_ff == 2'd0) begin
                  dph_in = 2'd1;
               end else if (dph_ff == 2'd1) begin
                  rr_in.ratio_num = 16'(dv_q);
                  dph_in = 2'd2;
               end else begin
                  rr_in.ratio_den  = 16'(dv_q);
                  rr_in.impossible = 1'b0;
                  dph_in   = 2'd0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rp_in    = rr_ff;
               rv_in    = 1'b1;
               cnt_in   = '0;
               dph_in   = 2'd0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // memory and divider controls
   always_comb begin
      em_we    = 1'b0;
      em_wa    = cnt_ff[EAW-1:0];
      em_wd    = {req_payload.end_a, req_payload.end_b, in_spd};
      em_ra    = i_ff[EAW-1:0];
      pm_we    = 1'b0;
      pm_wa    = x_ff;
      pm_wd    = x_ff;
      pm_ra    = x_ff;
      dv_start = 1'b0;
      dv_a     = ga_ff;
      dv_b     = gb_ff;
      unique case (state_ff)
         ST_LOAD: begin
            em_we = req_valid && !req_stall && in_spd != '0 &&
                    cnt_ff < ECW'(MAX_EDGES);
         end
         ST_SORT_RD: em_ra = i_ff[EAW-1:0];
         ST_SORT_CMP: begin
            em_ra = (k_ff != '0) ? k_in[EAW-1:0] - 1'b1 : '0;
            if (ph_ff) begin
               if (k_ff != '0 && e_s < key_ff[SW-1:0]) begin
                  em_we = 1'b1;
                  em_wa = k_ff[EAW-1:0];
                  em_wd = em_rd;
                  em_ra = (k_ff > ECW'(1)) ? k_ff[EAW-1:0] - 2'd2 : '0;
               end else begin
                  em_we = 1'b1;
                  em_wa = k_ff[EAW-1:0];
                  em_wd = key_ff;
                  em_ra = i_in[EAW-1:0];
               end
            end else begin
               em_ra = (k_ff != '0) ? k_ff[EAW-1:0] - 1'b1 : '0;
            end
         end
         ST_START: em_ra = i_ff[EAW-1:0];
         ST_EDGE_RD: em_ra = cur_ff ? k_ff[EAW-1:0] : i_ff[EAW-1:0];
         ST_CLEAR: pm_we = 1'b1;
         ST_FIND_A, ST_FIND_B, ST_FIND_S, ST_FIND_T: begin
            pm_ra = ph_ff ? pm_rd : x_ff;
            if (ph_ff && !(pm_rd == x_ff && pp_ff == x_ff) && pp_ff != x_ff) begin
               pm_we = 1'b1;
               pm_wa = x_ff;
               pm_wd = pm_rd;
               pm_ra = pm_rd;
            end
         end
         ST_LINK: begin
            pm_we = (ra_ff != x_ff);
            pm_wa = ra_ff;
            pm_wd = x_ff;
         end
         ST_GCD: begin
            dv_start = bfound_ff && dph_ff != 2'd0 && !dv_busy && state_in == ST_GCD;
            dv_a     = (dph_ff == 2'd2) ? gb_ff : ga_ff;
            dv_b     = (dph_ff == 2'd2) ? dv_r : gb_ff;
         end
         ST_DIV: begin
            dv_start = !dv_busy && dph_ff != 2'd2;
            dv_a     = (dph_ff == 2'd0) ? bmax_ff : bmin_ff;
            dv_b     = ga_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      k_ff    <= k_in;
      key_ff  <= key_in;
      hi_ff   <= hi_in;
      prev_ff <= prev_in;
      x_ff    <= x_in;
      ra_ff   <= ra_in;
      rs_ff   <= rs_in;
      eb_ff   <= eb_in;
      lo_ff   <= lo_in;
      pp_ff   <= pp_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      rp_ff   <= rp_in;
      rr_ff   <= rr_in;
      bmax_ff <= bmax_in;
      bmin_ff <= bmin_in;
      if (reset) begin
         state_ff  <= ST_LOAD;
         cnt_ff    <= '0;
         havep_ff  <= 1'b0;
         cur_ff    <= 1'b0;
         ph_ff     <= 1'b0;
         bfound_ff <= 1'b0;
         dph_ff    <= 2'd0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         havep_ff  <= havep_in;
         cur_ff    <= (state_ff == ST_START) ? 1'b0 : cur_in;
         ph_ff     <= ph_in;
         bfound_ff <= bfound_in;
         dph_ff    <= dph_in;
         rv_ff     <= rv_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/msrp_checker.sv
// ----------------------------------------------------------------------------
// msrp_checker
// port-level checks of the min speed ratio path unit
// ----------------------------------------------------------------------------
`default_nettype none
module msrp_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire msrp_pkg::req_payload_type req_payload,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire msrp_pkg::rsp_payload_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.last_edge |=> req_stall)
      else $error("transaction taken during search");
   a_impossible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.impossible |->
      rsp_payload.ratio_num == '0 && rsp_payload.ratio_den == '0)
      else $error("impossible result with nonzero ratio");
   a_ratio_ge_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.impossible |->
      rsp_payload.ratio_num >= rsp_payload.ratio_den && rsp_payload.ratio_den != '0)
      else $error("ratio below one");
endmodule

bind min_speed_ratio_path_unit msrp_checker u_msrp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_payload(rsp_payload)
);
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Loads edge sets into min_speed_ratio_path_unit under several vertex and
// route settings, predicts the reduced max/min speed ratio of every set with
// a sorted-edge union-find search of its own, and compares each response.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import msrp_pkg::*;

   localparam int unsigned VTX_LIMIT = 512;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [9:0]      csr_data;

   min_speed_ratio_path_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [9:0]      vertex_count_m;
   logic [9:0]      source_m;
   logic [9:0]      target_m;
   req_payload_type held_edges[$];
   req_payload_type ranked_edges[$];
   int unsigned     forest[VTX_LIMIT];
   rsp_payload_type ratio_expect_q[$];
   req_payload_type edge_pend_q[$];

   int   error_count;
   bit   req_taken;
   int   burst_left;
   int   gap_left;
   bit   gaps_on;
   bit   hold_request;
   bit   hold_started;
   int   hold_left;
   int   stall_mode;
   int   stall_phase;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #160000000;
      $display("testbench: done, errors");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int unsigned root_of(input int unsigned x);
      while (forest[x] != x) x = forest[x];
      return x;
   endfunction

   function automatic bit in_range(input int unsigned v, input int unsigned n);
      return v >= 1 && v <= n;
   endfunction

   function automatic rsp_payload_type route_ratio();
      int unsigned n, m, i, j, k, v, ra, rb, hi, lo, best_hi, best_lo, g, t;
      bit found;
      req_payload_type e;
      rsp_payload_type r;
      r = '0;
      n = vertex_count_m > VTX_LIMIT ? VTX_LIMIT : vertex_count_m;
      if (!in_range(source_m, n) || !in_range(target_m, n)) begin
         r.impossible = 1'b1;
         return r;
      end
      ranked_edges = {};
      foreach (held_edges[x]) begin
         e = held_edges[x];
         k = ranked_edges.size();
         ranked_edges.push_back(e);
         while (k > 0 && ranked_edges[k-1].speed < e.speed) begin
            ranked_edges[k] = ranked_edges[k-1];
            k--;
         end
         ranked_edges[k] = e;
      end
      m = ranked_edges.size();
      found = 0;
      best_hi = 0;
      best_lo = 0;
      for (i = 0; i < m; i++) begin
         if (i > 0 && ranked_edges[i].speed == ranked_edges[i-1].speed) continue;
         for (v = 0; v < n; v++) forest[v] = v;
         for (j = i; j < m; j++) begin
            if (in_range(ranked_edges[j].end_a, n) && in_range(ranked_edges[j].end_b, n)) begin
               ra = root_of(ranked_edges[j].end_a - 1);
               rb = root_of(ranked_edges[j].end_b - 1);
               if (ra != rb) forest[ra] = rb;
            end
            if (root_of(source_m - 1) == root_of(target_m - 1)) begin
               hi = ranked_edges[i].speed;
               lo = ranked_edges[j].speed;
               if (!found || longint'(best_hi) * lo > longint'(hi) * best_lo) begin
                  best_hi = hi;
                  best_lo = lo;
                  found = 1;
               end
               break;
            end
         end
      end
      if (!found) begin
         r.impossible = 1'b1;
         return r;
      end
      hi = best_hi;
      lo = best_lo;
      while (lo != 0) begin
         t = hi % lo;
         hi = lo;
         lo = t;
      end
      g = hi;
      r.ratio_num = 16'(best_hi / g);
      r.ratio_den = 16'(best_lo / g);
      return r;
   endfunction

   // accepted transactions on both channels
   always @(posedge clock) begin
      rsp_payload_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            if (req_payload.speed != 0) held_edges.push_back(req_payload);
            if (req_payload.last_edge) begin
               ratio_expect_q.push_back(route_ratio());
               held_edges = {};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (ratio_expect_q.size() == 0) begin
               $display("unexpected response transaction at %0t", $time);
               error_count++;
            end else begin
               want = ratio_expect_q.pop_front();
               if (rsp_payload.impossible != want.impossible)
                  report("impossible", rsp_payload.impossible, want.impossible);
               if (rsp_payload.ratio_num != want.ratio_num)
                  report("ratio_num", rsp_payload.ratio_num, want.ratio_num);
               if (rsp_payload.ratio_den != want.ratio_den)
                  report("ratio_den", rsp_payload.ratio_den, want.ratio_den);
            end
         end
      end
   end

   // edge driver, bursts with gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = gaps_on ? $urandom_range(0, 6) : 0;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (edge_pend_q.size() != 0) begin
            req_payload <= edge_pend_q.pop_front();
            req_valid <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern and one long hold-off
   always @(negedge clock) begin
      if (hold_request && !hold_started) begin
         hold_started = 1'b1;
         hold_left = 3000;
      end
      if (stall_phase == 0) begin
         stall_phase = $urandom_range(16, 96);
         stall_mode = $urandom_range(0, 2);
      end
      stall_phase--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [9:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_VERTEX_COUNT:  vertex_count_m = v;
         CSR_SOURCE_VERTEX: source_m = v;
         default:           target_m = v;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_edge(input int a, input int b, input int s, input bit last);
      req_payload_type p;
      p.end_a = 10'(a);
      p.end_b = 10'(b);
      p.speed = 16'(s);
      p.last_edge = last;
      edge_pend_q.push_back(p);
   endtask

   function automatic int pick_vertex();
      int unsigned n, r;
      n = vertex_count_m > VTX_LIMIT ? VTX_LIMIT : vertex_count_m;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(0, 1023);
      if (r == 2) return n + 1;
      return $urandom_range(1, n);
   endfunction

   task automatic add_route_set(input int m, inout int sent);
      int mode, s;
      mode = $urandom_range(0, 2);
      for (int i = 0; i < m; i++) begin
         case (mode)
            0: s = $urandom_range(1, 4);
            1: s = $urandom_range(1, 300);
            default: s = $urandom_range(1, 65535);
         endcase
         if ($urandom_range(0, 19) == 0) s = 0;
         add_edge(pick_vertex(), pick_vertex(), s, i == m - 1);
         sent++;
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (edge_pend_q.size() != 0 || req_valid || ratio_expect_q.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int sent, quota, sets;
      int unsigned cfg_n[10] = '{2, 8, 16, 1023, 512, 5, 6, 6, 32, 12};
      int unsigned cfg_s[10] = '{1, 1, 3, 1, 512, 3, 0, 2, 1, 7};
      int unsigned cfg_t[10] = '{2, 8, 12, 512, 1, 3, 4, 9, 32, 2};
      int ph;
      error_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_VERTEX_COUNT;
      csr_data = '0;
      burst_left = 0;
      gap_left = 0;
      gaps_on = 1'b0;
      hold_request = 1'b0;
      hold_started = 1'b0;
      hold_left = 0;
      stall_mode = 0;
      stall_phase = 0;
      vertex_count_m = 10'd2;
      source_m = 10'd1;
      target_m = 10'd2;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sets under reset settings, then with a vertex count of three
      add_edge(1, 2, 65535, 1);
      add_edge(1, 2, 0, 1);
      add_edge(1, 1, 5, 0);
      add_edge(2, 2, 7, 0);
      add_edge(1, 2, 3, 0);
      add_edge(2, 1, 65535, 1);
      add_edge(0, 2, 10, 0);
      add_edge(1, 3, 4, 0);
      add_edge(1023, 1023, 9, 0);
      add_edge(1, 2, 6, 1);
      add_edge(1, 2, 4, 0);
      add_edge(2, 1, 4, 1);
      add_edge(1, 1, 100, 1);
      sent = 13;
      wait_drained();
      csr_write(CSR_VERTEX_COUNT, 10'd3);
      add_edge(1, 2, 1, 0);
      add_edge(2, 3, 65535, 0);
      add_edge(1, 3, 32768, 0);
      add_edge(512, 1, 200, 1);
      sent += 4;
      wait_drained();

      ph = 0;
      while (sent < 1650) begin
         csr_write(CSR_VERTEX_COUNT, 10'(cfg_n[ph % 10]));
         csr_write(CSR_SOURCE_VERTEX, 10'(cfg_s[ph % 10]));
         csr_write(CSR_TARGET_VERTEX, 10'(cfg_t[ph % 10]));
         gaps_on = (ph % 3) != 0;
         if (cfg_n[ph % 10] >= 512) begin
            for (sets = 0; sets < 4; sets++) add_route_set($urandom_range(1, 6), sent);
         end else begin
            quota = sent + 150;
            if (ph == 2) add_route_set(40, sent);
            while (sent < quota) add_route_set($urandom_range(1, 12), sent);
         end
         if (ph == 1) hold_request = 1'b1;
         wait_drained();
         ph++;
      end

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
